@@ src/tcpq_pkg.sv @@
// Shared types and codes for the two-class priority queue.
// No dependencies; imported by every module under src.
package tcpq_pkg;

  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // per-class command, shared by every cell of the row
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

@@ src/tcpq_cell.sv @@
// One storage cell of a class row: a valid bit and a value.
// Depends on tcpq_pkg (cell_ctrl_t).
module tcpq_cell #(
  parameter int WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  tcpq_pkg::cell_ctrl_t ctrl,
  input  logic                prev_valid,
  input  logic                next_valid,
  input  logic [WIDTH-1:0]    next_data,
  input  logic [WIDTH-1:0]    in_data,
  output logic                valid,
  output logic [WIDTH-1:0]    data
);
  import tcpq_pkg::*;

  logic take;

  // the first empty cell behind a full one takes the pushed value
  assign take = ctrl.push && !valid && prev_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.pop) begin
      valid <= next_valid;
    end else if (take) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.pop) begin
      data <= next_data;
    end else if (take) begin
      data <= in_data;
    end
  end

endmodule

@@ src/tcpq_class.sv @@
// One class FIFO: a row of cells that shifts toward the front on a pop,
// plus the occupancy count. Depends on tcpq_pkg and tcpq_cell.
module tcpq_class #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int CW    = 5
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tcpq_pkg::cell_ctrl_t ctrl,
  input  logic [WIDTH-1:0]     in_data,
  output logic [WIDTH-1:0]     front_data,
  output logic [CW-1:0]        count,
  output logic                 full
);
  import tcpq_pkg::*;

  // chain_valid[i+1] is cell i; ends tie to "full" before and "empty" after
  logic [DEPTH+1:0] chain_valid;
  logic [WIDTH-1:0] chain_data [0:DEPTH];

  assign chain_valid[0]       = 1'b1;
  assign chain_valid[DEPTH+1] = 1'b0;
  assign chain_data[DEPTH]    = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    tcpq_cell #(.WIDTH(WIDTH)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .prev_valid (chain_valid[i]),
      .next_valid (chain_valid[i+2]),
      .next_data  (chain_data[i+1]),
      .in_data    (in_data),
      .valid      (chain_valid[i+1]),
      .data       (chain_data[i])
    );
  end

  assign front_data = chain_data[0];
  assign full       = chain_valid[DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.pop) begin
      count <= count - CW'(1);
    end else if (ctrl.push && !full) begin
      count <= count + CW'(1);
    end
  end

endmodule

@@ src/two_class_priority_queue.sv @@
// Two-class priority queue: each class is a row of CLASS_DEPTH cells.
// Throughput: one transaction per cycle while out_ready takes each result; one result per input transaction.
// Latency: the result is valid the cycle after the input is accepted; a new
// input is taken only when no result is held or the held one leaves that cycle.
// Reset (rst, synchronous): both classes empty, no result pending.
module two_class_priority_queue #(
  parameter int CLASS_DEPTH = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [31:0] value,
  input  logic        is_priority,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] front_value,
  output logic        front_valid,
  output logic        front_is_priority,
  output logic [4:0]  priority_count,
  output logic [4:0]  secondary_count,
  output logic [1:0]  status
);
  import tcpq_pkg::*;

  localparam int CW = $clog2(CLASS_DEPTH + 1);

  logic                   accept;
  logic                   is_enq;
  logic                   is_deq;
  logic [VALUE_WIDTH+31:0] value_ext;
  logic [VALUE_WIDTH-1:0] in_data;
  cell_ctrl_t             p_ctrl;
  cell_ctrl_t             s_ctrl;
  logic [VALUE_WIDTH-1:0] p_front;
  logic [VALUE_WIDTH-1:0] s_front;
  logic [CW-1:0]          p_count;
  logic [CW-1:0]          s_count;
  logic                   p_full;
  logic                   s_full;
  logic                   p_any;
  logic                   s_any;
  logic [VALUE_WIDTH-1:0] front_sel;
  logic [VALUE_WIDTH+31:0] front_ext;
  logic [CW+4:0]          p_count_ext;
  logic [CW+4:0]          s_count_ext;
  logic [1:0]             status_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign is_enq   = accept && (opcode == OP_ENQUEUE);
  assign is_deq   = accept && (opcode == OP_DEQUEUE);

  assign value_ext = {{VALUE_WIDTH{1'b0}}, value};
  assign in_data   = value_ext[VALUE_WIDTH-1:0];

  assign p_any = (p_count != '0);
  assign s_any = (s_count != '0);

  assign p_ctrl.push = is_enq && is_priority;
  assign p_ctrl.pop  = is_deq && p_any;
  assign s_ctrl.push = is_enq && !is_priority;
  assign s_ctrl.pop  = is_deq && !p_any && s_any;

  tcpq_class #(.DEPTH(CLASS_DEPTH), .WIDTH(VALUE_WIDTH), .CW(CW)) u_prio (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (p_ctrl),
    .in_data    (in_data),
    .front_data (p_front),
    .count      (p_count),
    .full       (p_full)
  );

  tcpq_class #(.DEPTH(CLASS_DEPTH), .WIDTH(VALUE_WIDTH), .CW(CW)) u_sec (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (s_ctrl),
    .in_data    (in_data),
    .front_data (s_front),
    .count      (s_count),
    .full       (s_full)
  );

  always_comb begin
    status_next = STATUS_OK;
    if (is_deq && !p_any && !s_any) begin
      status_next = STATUS_EMPTY;
    end else if (is_enq && (is_priority ? p_full : s_full)) begin
      status_next = STATUS_FULL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  // state only moves on an accepted transaction, so the result fields can
  // be read straight off the class rows while a result is held
  always_comb begin
    front_sel = '0;
    if (p_any) begin
      front_sel = p_front;
    end else if (s_any) begin
      front_sel = s_front;
    end
  end

  assign front_ext         = {32'b0, front_sel};
  assign front_value       = front_ext[31:0];
  assign front_valid       = p_any || s_any;
  assign front_is_priority = p_any;
  assign p_count_ext       = {5'b0, p_count};
  assign s_count_ext       = {5'b0, s_count};
  assign priority_count    = p_count_ext[4:0];
  assign secondary_count   = s_count_ext[4:0];

endmodule

@@ dv/tb_top.sv @@
// Testbench for two_class_priority_queue: directed and random transactions,
// checked against an in-bench model of the two class FIFOs.
// Depends on src/tcpq_pkg.sv and src/two_class_priority_queue.sv.
`timescale 1ns / 1ps

module tb_top;
  import tcpq_pkg::*;

  localparam int DEPTH       = 16;
  localparam int CYCLE_LIMIT = 100000;

  typedef struct packed {
    logic [31:0] front_value;
    logic        front_valid;
    logic        front_is_priority;
    logic [4:0]  priority_count;
    logic [4:0]  secondary_count;
    logic [1:0]  status;
  } front_state_t;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [31:0] value;
  logic        is_priority;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] front_value;
  logic        front_valid;
  logic        front_is_priority;
  logic [4:0]  priority_count;
  logic [4:0]  secondary_count;
  logic [1:0]  status;

  logic [31:0]  priority_fifo[$];
  logic [31:0]  secondary_fifo[$];
  front_state_t expected_fronts[$];

  int  error_count;
  int  cycle_count;
  bit  send_gaps;
  bit  recv_stalls;

  two_class_priority_queue #(
    .CLASS_DEPTH(DEPTH),
    .VALUE_WIDTH(32)
  ) uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .opcode           (opcode),
    .value            (value),
    .is_priority      (is_priority),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .front_value      (front_value),
    .front_valid      (front_valid),
    .front_is_priority(front_is_priority),
    .priority_count   (priority_count),
    .secondary_count  (secondary_count),
    .status           (status)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Apply one accepted transaction to the queue model and record the result.
  task automatic queue_model_apply(input logic op, input logic [31:0] val,
                                   input logic prio);
    front_state_t r;
    r = '0;
    r.status = STATUS_OK;
    if (op == OP_ENQUEUE) begin
      if (prio) begin
        if (priority_fifo.size() >= DEPTH) r.status = STATUS_FULL;
        else priority_fifo.push_back(val);
      end else begin
        if (secondary_fifo.size() >= DEPTH) r.status = STATUS_FULL;
        else secondary_fifo.push_back(val);
      end
    end else begin
      if (priority_fifo.size() > 0) void'(priority_fifo.pop_front());
      else if (secondary_fifo.size() > 0) void'(secondary_fifo.pop_front());
      else r.status = STATUS_EMPTY;
    end
    if (priority_fifo.size() > 0) begin
      r.front_value       = priority_fifo[0];
      r.front_valid       = 1'b1;
      r.front_is_priority = 1'b1;
    end else if (secondary_fifo.size() > 0) begin
      r.front_value = secondary_fifo[0];
      r.front_valid = 1'b1;
    end
    r.priority_count  = 5'(priority_fifo.size());
    r.secondary_count = 5'(secondary_fifo.size());
    expected_fronts.push_back(r);
  endtask

  // Called just after a falling edge; returns just after the next falling
  // edge following acceptance, with in_valid still high.
  task automatic issue_op(input logic op, input logic [31:0] val, input logic prio);
    if (send_gaps && $urandom_range(99) < 12) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    opcode      = op;
    value       = val;
    is_priority = prio;
    do @(posedge clk); while (!in_ready);
    queue_model_apply(op, val, prio);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (recv_stalls) out_ready = ($urandom_range(99) >= 12);
    else out_ready = 1'b1;
  end

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    front_state_t e;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (expected_fronts.size() == 0) begin
        $error("result with no transaction outstanding");
        error_count++;
      end else begin
        e = expected_fronts.pop_front();
        check_field("front_value", e.front_value, front_value);
        check_field("front_valid", e.front_valid, front_valid);
        check_field("front_is_priority", e.front_is_priority, front_is_priority);
        check_field("priority_count", e.priority_count, priority_count);
        check_field("secondary_count", e.secondary_count, secondary_count);
        check_field("status", e.status, status);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Empty dequeue, value extremes in both classes, strict class ordering.
  task automatic test_empty_and_extremes();
    issue_op(OP_DEQUEUE, 32'hFFFF_FFFF, 1'b1);
    issue_op(OP_ENQUEUE, 32'h0000_0000, 1'b0);
    issue_op(OP_ENQUEUE, 32'hFFFF_FFFF, 1'b0);
    issue_op(OP_ENQUEUE, 32'hFFFF_FFFF, 1'b1);
    issue_op(OP_ENQUEUE, 32'h0000_0000, 1'b1);
    repeat (4) issue_op(OP_DEQUEUE, 32'h0, 1'b0);
    issue_op(OP_DEQUEUE, 32'h0, 1'b0);
  endtask

  // Fill the priority class, overflow it, and show the other class still takes entries.
  task automatic test_class_full();
    for (int i = 0; i < DEPTH; i++)
      issue_op(OP_ENQUEUE, $urandom(), 1'b1);
    issue_op(OP_ENQUEUE, 32'hA5A5_5A5A, 1'b1);
    issue_op(OP_ENQUEUE, 32'h5A5A_A5A5, 1'b0);
  endtask

  // Each phase randomly leans toward filling or draining so both classes hit
  // full and empty many times.
  task automatic run_random_ops(input int n_items);
    int left;
    int phase_len;
    int enq_pct;
    int prio_pct;
    logic [31:0] v;
    left = n_items;
    while (left > 0) begin
      phase_len = $urandom_range(40, 10);
      enq_pct   = ($urandom_range(1) != 0) ? 80 : 25;
      case ($urandom_range(2))
        0:       prio_pct = 10;
        1:       prio_pct = 50;
        default: prio_pct = 90;
      endcase
      for (int i = 0; i < phase_len && left > 0; i++) begin
        case ($urandom_range(9))
          0:       v = 32'h0;
          1:       v = 32'hFFFF_FFFF;
          default: v = $urandom();
        endcase
        issue_op(($urandom_range(99) < enq_pct) ? OP_ENQUEUE : OP_DEQUEUE, v,
                 $urandom_range(99) < prio_pct);
        left--;
      end
    end
  endtask

  task automatic test_back_to_back();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    run_random_ops(120);
  endtask

  task automatic test_random_with_stalls();
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    run_random_ops(330);
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    opcode      = OP_ENQUEUE;
    value       = '0;
    is_priority = 1'b0;
    out_ready   = 1'b1;
    error_count = 0;
    cycle_count = 0;
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_and_extremes();
    test_class_full();
    test_back_to_back();
    test_random_with_stalls();

    in_valid = 1'b0;
    while (expected_fronts.size() > 0) @(negedge clk);
    repeat (5) @(negedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/tcpq_pkg.sv
src/tcpq_cell.sv
src/tcpq_class.sv
src/two_class_priority_queue.sv
dv/tb_top.sv
